[rtl/crc_pkg.sv]
// Shared types and constants for the clique row classifier.
// No dependencies; used by every module under rtl/.
package crc_pkg;

    localparam int VAL_W   = 48;
    localparam int RHS_W   = 56;
    localparam int ROW_W   = 20;
    localparam int SENSE_W = 2;

    localparam logic [SENSE_W-1:0] SENSE_L = 2'd0;
    localparam logic [SENSE_W-1:0] SENSE_G = 2'd1;

    localparam logic signed [VAL_W-1:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [RHS_W-1:0] RHS_MAX  = 56'sh7F_FFFF_FFFF_FFFF;
    localparam logic signed [RHS_W-1:0] RHS_MIN  = 56'sh80_0000_0000_0000;

    // Running row summary handed from the tracking stage to the verdict stage.
    typedef struct packed {
        logic                    row_ok;
        logic                    sense_ok;
        logic                    len_ok;
        logic signed [VAL_W-1:0] smallest;
        logic signed [VAL_W-1:0] second;
        logic signed [RHS_W-1:0] rhs;
    } row_sum_t;

endpackage

[rtl/crc_row_track.sv]
// Per-nonzero row tracking: literal, complemented rhs, two smallest coefficients.
// Depends on crc_pkg.
module crc_row_track #(
    parameter int MAX_ROW_LEN   = 256,
    parameter int COLUMN_BITS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                update,
    input  logic [crc_pkg::SENSE_W-1:0]         in_sense,
    input  logic signed [crc_pkg::VAL_W-1:0]    in_rhs,
    input  logic [COLUMN_BITS-1:0]              in_column,
    input  logic signed [crc_pkg::VAL_W-1:0]    in_coef,
    input  logic                                in_integer,
    input  logic signed [crc_pkg::VAL_W-1:0]    in_lb,
    input  logic signed [crc_pkg::VAL_W-1:0]    in_ub,
    input  logic                                in_last,
    input  logic [COLUMN_BITS:0]                column_count,
    output logic [COLUMN_BITS:0]                literal,
    output crc_pkg::row_sum_t                   row_sum
);

    localparam int CNT_W = $clog2(MAX_ROW_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ROW_LEN);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
    localparam longint EPS_VAL = ((longint'(1) << FRACTION_BITS) + 500000) / 1000000;
    localparam logic signed [crc_pkg::VAL_W:0] EPS     = (crc_pkg::VAL_W + 1)'(EPS_VAL);
    localparam logic signed [crc_pkg::VAL_W:0] NEG_EPS = -EPS;
    localparam logic signed [crc_pkg::VAL_W-1:0] FIX_ONE =
        crc_pkg::VAL_W'(longint'(1) << FRACTION_BITS);
    localparam logic signed [crc_pkg::VAL_W:0] COEF_MAX_X = {1'b0, crc_pkg::COEF_MAX};

    logic                               start_reg;
    logic [crc_pkg::SENSE_W-1:0]        sense_reg, sense_next;
    logic signed [crc_pkg::RHS_W-1:0]   rhs_reg, rhs_next;
    logic signed [crc_pkg::VAL_W-1:0]   min_reg, min_next;
    logic signed [crc_pkg::VAL_W-1:0]   sec_reg, sec_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               ok_reg, ok_next;
    logic [COLUMN_BITS:0]               lit_reg, lit_next;

    logic signed [crc_pkg::RHS_W-1:0]   rhs_in_x, rhs_base;
    logic signed [crc_pkg::VAL_W-1:0]   min_base, sec_base, c_clamp;
    logic [CNT_W-1:0]                   cnt_base;
    logic                               ok_base, binary, neg;
    logic signed [crc_pkg::VAL_W:0]     coef_x, c_signed, c_abs, c_eps, min_x, sec_x;
    logic signed [crc_pkg::RHS_W:0]     rhs_sum;
    logic signed [crc_pkg::RHS_W-1:0]   rhs_sat;

    always_comb begin
        sense_next = start_reg ? in_sense : sense_reg;
        rhs_in_x   = {{(crc_pkg::RHS_W - crc_pkg::VAL_W){in_rhs[crc_pkg::VAL_W-1]}}, in_rhs};
        if (start_reg) begin
            rhs_base = (in_sense == crc_pkg::SENSE_G) ? -rhs_in_x : rhs_in_x;
            min_base = crc_pkg::COEF_MAX;
            sec_base = crc_pkg::COEF_MAX;
            cnt_base = '0;
            ok_base  = 1'b1;
        end else begin
            rhs_base = rhs_reg;
            min_base = min_reg;
            sec_base = sec_reg;
            cnt_base = cnt_reg;
            ok_base  = ok_reg;
        end

        coef_x   = {in_coef[crc_pkg::VAL_W-1], in_coef};
        c_signed = (sense_next == crc_pkg::SENSE_G) ? -coef_x : coef_x;
        binary   = in_integer && (in_lb == '0 || in_lb == FIX_ONE)
                   && (in_ub == '0 || in_ub == FIX_ONE);
        ok_next  = ok_base && binary;

        neg      = (c_signed <= NEG_EPS);
        c_abs    = neg ? -c_signed : c_signed;
        lit_next = neg ? (column_count + {1'b0, in_column}) : {1'b0, in_column};

        rhs_sum  = {rhs_base[crc_pkg::RHS_W-1], rhs_base}
                   + {{(crc_pkg::RHS_W - crc_pkg::VAL_W){c_abs[crc_pkg::VAL_W]}}, c_abs};
        if (rhs_sum[crc_pkg::RHS_W] != rhs_sum[crc_pkg::RHS_W-1])
            rhs_sat = rhs_sum[crc_pkg::RHS_W] ? crc_pkg::RHS_MIN : crc_pkg::RHS_MAX;
        else
            rhs_sat = rhs_sum[crc_pkg::RHS_W-1:0];
        rhs_next = (neg && ok_next) ? rhs_sat : rhs_base;

        c_clamp  = (c_abs > COEF_MAX_X) ? crc_pkg::COEF_MAX : c_abs[crc_pkg::VAL_W-1:0];
        c_eps    = {c_clamp[crc_pkg::VAL_W-1], c_clamp} + EPS;
        min_x    = {min_base[crc_pkg::VAL_W-1], min_base};
        sec_x    = {sec_base[crc_pkg::VAL_W-1], sec_base};
        min_next = min_base;
        sec_next = sec_base;
        if (ok_next) begin
            if (c_eps <= min_x) begin
                sec_next = min_base;
                min_next = c_clamp;
            end else if (c_eps <= sec_x) begin
                sec_next = c_clamp;
            end
        end

        cnt_next = (cnt_base <= CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
        end else if (update) begin
            start_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            sense_reg <= sense_next;
            rhs_reg   <= rhs_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            cnt_reg   <= cnt_next;
            ok_reg    <= ok_next;
            lit_reg   <= lit_next;
        end
    end

    assign literal           = lit_reg;
    assign row_sum.row_ok    = ok_reg;
    assign row_sum.sense_ok  = (sense_reg == crc_pkg::SENSE_L) || (sense_reg == crc_pkg::SENSE_G);
    assign row_sum.len_ok    = (cnt_reg >= CNT_MIN) && (cnt_reg <= CNT_MAX);
    assign row_sum.smallest  = min_reg;
    assign row_sum.second    = sec_reg;
    assign row_sum.rhs       = rhs_reg;

endmodule

[rtl/crc_verdict.sv]
// Row verdict, clique row numbering and the result register.
// Depends on crc_pkg.
module crc_verdict #(
    parameter int COLUMN_BITS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic                        in_last,
    input  logic [crc_pkg::ROW_W-1:0]   in_row,
    input  logic [COLUMN_BITS:0]        in_literal,
    input  crc_pkg::row_sum_t           row_sum,
    output logic                        out_valid,
    output logic                        out_last,
    output logic [crc_pkg::ROW_W-1:0]   out_row,
    output logic [COLUMN_BITS:0]        out_literal,
    output logic                        out_clique,
    output logic [crc_pkg::ROW_W-1:0]   out_number
);

    localparam longint EPS_VAL = ((longint'(1) << FRACTION_BITS) + 500000) / 1000000;
    localparam logic signed [crc_pkg::RHS_W+1:0] EPS = (crc_pkg::RHS_W + 2)'(EPS_VAL);

    logic                               valid_reg;
    logic                               last_reg;
    logic [crc_pkg::ROW_W-1:0]          row_reg;
    logic [COLUMN_BITS:0]               lit_reg;
    logic                               clique_reg;
    logic [crc_pkg::ROW_W-1:0]          number_reg;
    logic [crc_pkg::ROW_W-1:0]          accepted_reg;

    logic signed [crc_pkg::RHS_W+1:0]   pair_sum, threshold;
    logic                               clique;

    always_comb begin
        pair_sum  = {{(crc_pkg::RHS_W + 2 - crc_pkg::VAL_W){row_sum.smallest[crc_pkg::VAL_W-1]}},
                     row_sum.smallest}
                  + {{(crc_pkg::RHS_W + 2 - crc_pkg::VAL_W){row_sum.second[crc_pkg::VAL_W-1]}},
                     row_sum.second};
        threshold = {{2{row_sum.rhs[crc_pkg::RHS_W-1]}}, row_sum.rhs} + EPS;
        clique    = in_last && row_sum.row_ok && row_sum.len_ok && row_sum.sense_ok
                    && (pair_sum >= threshold);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            accepted_reg <= '0;
        end else if (advance) begin
            valid_reg <= in_valid;
            if (in_valid && clique)
                accepted_reg <= accepted_reg + crc_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            last_reg   <= in_last;
            row_reg    <= in_row;
            lit_reg    <= in_literal;
            clique_reg <= clique;
            number_reg <= clique ? accepted_reg : '0;
        end
    end

    assign out_valid   = valid_reg;
    assign out_last    = last_reg;
    assign out_row     = row_reg;
    assign out_literal = lit_reg;
    assign out_clique  = clique_reg;
    assign out_number  = number_reg;

endmodule

[rtl/clique_row_classifier.sv]
// Clique row classifier top level: input register, row tracking, verdict stage.
// Depends on crc_pkg, crc_row_track and crc_verdict.
//
// Nonzeros of constraint rows stream in, one per transaction, tlast on the last
// nonzero of a row. Every nonzero gives exactly one result transaction carrying
// its literal and row index; the result with tlast set also carries the verdict
// in m_tuser and, for a clique row, its running clique number. One nonzero is
// taken every cycle while the pipeline does not stall; its result is registered in
// the input register, then the tracking stage (row state update), then the verdict
// into the result register, where it is presented. The pipeline stalls as a whole
// only when the result register is full and not taken.
// column_count may be written only while no transaction is in flight.
module clique_row_classifier #(
    parameter int MAX_ROW_LEN   = 256,
    parameter int COLUMN_BITS   = 16,
    parameter int FRACTION_BITS = 24,
    localparam int S_DATA_W =
        ((4 * crc_pkg::VAL_W + crc_pkg::ROW_W + COLUMN_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W = ((COLUMN_BITS + 1 + 2 * crc_pkg::ROW_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [COLUMN_BITS:0]    cfg_data,     // column_count
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // row_number, right_side, column, coefficient, column_integer,
    // lower_bound, upper_bound, zero fill
    input  logic [S_DATA_W-1:0]     s_tdata,
    input  logic [1:0]              s_tuser,      // row_sense
    input  logic                    s_tlast,      // row_end
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // literal, row_echo, clique_number, zero fill
    output logic [M_DATA_W-1:0]     m_tdata,
    output logic                    m_tuser,      // is_clique
    output logic                    m_tlast       // row_done
);

    localparam int VW      = crc_pkg::VAL_W;
    localparam int RW      = crc_pkg::ROW_W;
    localparam int RHS_LO  = RW;
    localparam int COL_LO  = RHS_LO + VW;
    localparam int COEF_LO = COL_LO + COLUMN_BITS;
    localparam int INT_LO  = COEF_LO + VW;
    localparam int LB_LO   = INT_LO + 1;
    localparam int UB_LO   = LB_LO + VW;
    localparam int M_USED  = COLUMN_BITS + 1 + 2 * RW;

    logic                           advance;
    logic [COLUMN_BITS:0]           cc_reg;

    logic                           v0_reg;
    logic [RW-1:0]                  row0_reg;
    logic [crc_pkg::SENSE_W-1:0]    sense0_reg;
    logic signed [VW-1:0]           rhs0_reg, coef0_reg, lb0_reg, ub0_reg;
    logic [COLUMN_BITS-1:0]         col0_reg;
    logic                           int0_reg, last0_reg;

    logic                           v1_reg, last1_reg;
    logic [RW-1:0]                  row1_reg;

    logic [COLUMN_BITS:0]           literal1;
    crc_pkg::row_sum_t              row_sum;

    logic                           out_valid, out_last, out_clique;
    logic [RW-1:0]                  out_row, out_number;
    logic [COLUMN_BITS:0]           out_literal;

    assign advance   = !out_valid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= (COLUMN_BITS + 1)'(1) << COLUMN_BITS;
        end else if (cfg_valid) begin
            cc_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            row0_reg   <= s_tdata[RW-1:0];
            sense0_reg <= s_tuser;
            rhs0_reg   <= s_tdata[RHS_LO +: VW];
            col0_reg   <= s_tdata[COL_LO +: COLUMN_BITS];
            coef0_reg  <= s_tdata[COEF_LO +: VW];
            int0_reg   <= s_tdata[INT_LO];
            lb0_reg    <= s_tdata[LB_LO +: VW];
            ub0_reg    <= s_tdata[UB_LO +: VW];
            last0_reg  <= s_tlast;
            row1_reg   <= row0_reg;
            last1_reg  <= last0_reg;
        end
    end

    crc_row_track #(
        .MAX_ROW_LEN   (MAX_ROW_LEN),
        .COLUMN_BITS   (COLUMN_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update       (advance && v0_reg),
        .in_sense     (sense0_reg),
        .in_rhs       (rhs0_reg),
        .in_column    (col0_reg),
        .in_coef      (coef0_reg),
        .in_integer   (int0_reg),
        .in_lb        (lb0_reg),
        .in_ub        (ub0_reg),
        .in_last      (last0_reg),
        .column_count (cc_reg),
        .literal      (literal1),
        .row_sum      (row_sum)
    );

    crc_verdict #(
        .COLUMN_BITS   (COLUMN_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_verdict (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (v1_reg),
        .in_last     (last1_reg),
        .in_row      (row1_reg),
        .in_literal  (literal1),
        .row_sum     (row_sum),
        .out_valid   (out_valid),
        .out_last    (out_last),
        .out_row     (out_row),
        .out_literal (out_literal),
        .out_clique  (out_clique),
        .out_number  (out_number)
    );

    assign m_tvalid = out_valid;
    assign m_tlast  = out_last;
    assign m_tuser  = out_clique;
    assign m_tdata  = {{(M_DATA_W - M_USED){1'b0}}, out_number, out_row, out_literal};

endmodule

[verif/testbench.sv]
// Self-checking bench for clique_row_classifier: directed rows, then random rows under
// several column_count settings, with random idling on both stream sides.
// Depends on crc_pkg and the clique_row_classifier RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int     VAL_W         = crc_pkg::VAL_W;
    localparam int     MAX_ROW_LEN   = 256;
    localparam int     FRACTION_BITS = 24;
    localparam int     S_DATA_W      = 232;
    localparam int     M_DATA_W      = 64;
    localparam int     LATENCY       = 3;
    localparam int     HOLD_CYCLES   = 100;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     PHASE_ITEMS   = 220;
    localparam longint FIX_ONE       = 64'sd1 <<< FRACTION_BITS;
    localparam longint EPS_LSB       = (FIX_ONE + 500000) / 1000000;
    localparam longint COEF_TOP      = longint'(crc_pkg::COEF_MAX);
    localparam longint RHS_TOP       = longint'(crc_pkg::RHS_MAX);
    localparam longint RHS_BOTTOM    = longint'(crc_pkg::RHS_MIN);

    localparam logic [crc_pkg::SENSE_W-1:0] SENSE_L     = crc_pkg::SENSE_L;
    localparam logic [crc_pkg::SENSE_W-1:0] SENSE_G     = crc_pkg::SENSE_G;
    localparam logic [crc_pkg::SENSE_W-1:0] SENSE_OTHER = 2'd2;
    localparam logic [crc_pkg::SENSE_W-1:0] SENSE_SPARE = 2'd3;

    typedef struct packed {
        logic [19:0]       row_number;
        logic [1:0]        row_sense;
        logic [VAL_W-1:0]  right_side;
        logic [15:0]       column;
        logic [VAL_W-1:0]  coefficient;
        logic              column_integer;
        logic [VAL_W-1:0]  lower_bound;
        logic [VAL_W-1:0]  upper_bound;
        logic              row_end;
    } nonzero_t;

    typedef struct packed {
        logic [16:0] literal;
        logic        row_done;
        logic [19:0] row_echo;
        logic        is_clique;
        logic [19:0] clique_number;
    } result_t;

    class clique_scoreboard;
        bit [16:0]    col_offset;
        bit           at_row_start;
        bit [1:0]     held_sense;
        longint       rhs_acc;
        longint       min_first;
        longint       min_second;
        int unsigned  nz_count;
        bit           row_binary;
        bit [19:0]    clique_count;
        result_t      pending[$];
        int           errors;
        int           rows_done;
        int           cliques;

        function new();
            col_offset   = 17'd65536;
            at_row_start = 1'b1;
            held_sense   = SENSE_L;
            rhs_acc      = 0;
            min_first    = COEF_TOP;
            min_second   = COEF_TOP;
            nz_count     = 0;
            row_binary   = 1'b1;
            clique_count = '0;
        endfunction

        function void set_column_count(bit [16:0] value);
            col_offset = value;
        endfunction

        function void note_nonzero(nonzero_t nz);
            longint  c;
            longint  lb;
            longint  ub;
            longint  sum;
            result_t r;
            if (at_row_start) begin
                held_sense = nz.row_sense;
                rhs_acc    = longint'($signed(nz.right_side));
                if (held_sense == SENSE_G) rhs_acc = -rhs_acc;
                min_first  = COEF_TOP;
                min_second = COEF_TOP;
                nz_count   = 0;
                row_binary = 1'b1;
            end
            c  = longint'($signed(nz.coefficient));
            lb = longint'($signed(nz.lower_bound));
            ub = longint'($signed(nz.upper_bound));
            if (held_sense == SENSE_G) c = -c;
            if (!(nz.column_integer && (lb == 0 || lb == FIX_ONE) && (ub == 0 || ub == FIX_ONE)))
                row_binary = 1'b0;

            r = '0;
            r.literal = {1'b0, nz.column};
            if (c <= -EPS_LSB) begin
                r.literal = 17'(nz.column + col_offset);
                c = -c;
                if (row_binary) begin
                    sum = rhs_acc + c;
                    rhs_acc = (sum > RHS_TOP) ? RHS_TOP : (sum < RHS_BOTTOM) ? RHS_BOTTOM : sum;
                end
            end
            if (c > COEF_TOP) c = COEF_TOP;

            if (row_binary) begin
                if (c + EPS_LSB <= min_first) begin
                    min_second = min_first;
                    min_first  = c;
                end else if (c + EPS_LSB <= min_second) begin
                    min_second = c;
                end
            end
            if (nz_count <= MAX_ROW_LEN) nz_count++;

            r.row_done = nz.row_end;
            r.row_echo = nz.row_number;
            if (nz.row_end && row_binary && nz_count >= 2 && nz_count <= MAX_ROW_LEN &&
                (held_sense == SENSE_L || held_sense == SENSE_G) &&
                min_first + min_second >= rhs_acc + EPS_LSB) begin
                r.is_clique     = 1'b1;
                r.clique_number = clique_count;
                clique_count++;
            end
            at_row_start = nz.row_end;
            pending.insert(pending.size(), r);
        endfunction

        function void compare_field(string name, logic [19:0] want, logic [19:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: literal %0d row %0d",
                       got.literal, got.row_echo);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("literal", 20'(want.literal), 20'(got.literal));
            compare_field("row_done", 20'(want.row_done), 20'(got.row_done));
            compare_field("row_echo", want.row_echo, got.row_echo);
            compare_field("is_clique", 20'(want.is_clique), 20'(got.is_clique));
            compare_field("clique_number", want.clique_number, got.clique_number);
            if (got.row_done === 1'b1) rows_done++;
            if (got.is_clique === 1'b1) cliques++;
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [16:0]         cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    clique_scoreboard sb = new();
    int  nz_accepted = 0;
    int  burst_left  = 0;
    int  settings    = 1;
    bit  held_once   = 1'b0;
    int  idle_cycles = 0;

    clique_row_classifier #(
        .MAX_ROW_LEN   (MAX_ROW_LEN),
        .COLUMN_BITS   (16),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint rand_val();
        logic [VAL_W-1:0] v;
        v = {16'($urandom), 32'($urandom)};
        return longint'($signed(v));
    endfunction

    // whole units in [lo, hi], sometimes nudged by a few LSB around the tolerance
    function automatic longint near_units(int lo, int hi);
        longint v;
        v = longint'(int'($urandom_range(0, hi - lo)) + lo) * FIX_ONE;
        if ($urandom_range(0, 3) == 0) v += int'($urandom_range(0, 80)) - 40;
        return v;
    endfunction

    function automatic nonzero_t make_nz(logic [19:0] row, logic [1:0] sense, longint rhs,
                                         logic [15:0] col, longint coef, logic intg,
                                         longint lb, longint ub, logic last);
        nonzero_t nz;
        nz.row_number     = row;
        nz.row_sense      = sense;
        nz.right_side     = rhs[VAL_W-1:0];
        nz.column         = col;
        nz.coefficient    = coef[VAL_W-1:0];
        nz.column_integer = intg;
        nz.lower_bound    = lb[VAL_W-1:0];
        nz.upper_bound    = ub[VAL_W-1:0];
        nz.row_end        = last;
        return nz;
    endfunction

    function automatic void append_nz(ref nonzero_t q[$], input nonzero_t nz);
        q.insert(q.size(), nz);
    endfunction

    // Mostly well-formed binary L/G rows; some with one non-binary column, some pure
    // noise, and rare rows around MAX_ROW_LEN with huge coefficients that saturate rhs.
    function automatic void gen_row(ref nonzero_t row_q[$]);
        int          kind;
        int          len;
        int          bad_at;
        logic [19:0] row;
        logic [1:0]  sense;
        longint      rhs;
        longint      coef;
        longint      lb;
        longint      ub;
        logic        intg;
        kind   = $urandom_range(0, 99);
        row    = 20'($urandom);
        sense  = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
        rhs    = (sense == SENSE_G) ? -FIX_ONE : FIX_ONE;
        if ($urandom_range(0, 1)) rhs = near_units(-2, 3);
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 6);
        if (kind < 2) begin
            len = $urandom_range(MAX_ROW_LEN - 1, MAX_ROW_LEN + 3);
            rhs = rand_val();
        end
        bad_at = (kind >= 72 && kind < 88) ? $urandom_range(0, len - 1) : -1;
        row_q.delete();
        for (int i = 0; i < len; i++) begin
            intg = 1'b1;
            lb   = $urandom_range(0, 1) ? FIX_ONE : 0;
            ub   = $urandom_range(0, 1) ? FIX_ONE : 0;
            if (kind < 2)
                coef = (sense == SENSE_G) ? COEF_TOP : -COEF_TOP - 1;
            else if ($urandom_range(0, 1))
                coef = (sense == SENSE_G) ? -FIX_ONE : FIX_ONE;
            else
                coef = near_units(-3, 3);
            if (i == bad_at) begin
                case ($urandom_range(0, 3))
                    0: intg = 1'b0;
                    1: lb = -FIX_ONE;
                    2: ub = 2 * FIX_ONE;
                    default: lb = rand_val();
                endcase
            end
            if (kind >= 88) begin
                coef = rand_val();
                intg = 1'($urandom);
                lb   = rand_val();
                ub   = rand_val();
            end
            append_nz(row_q, make_nz(row, (i == 0 && kind < 88) ? sense : 2'($urandom),
                                     (i == 0 && kind < 88) ? rhs : rand_val(),
                                     16'($urandom), coef, intg, lb, ub, i == len - 1));
        end
    endfunction

    task automatic send_nonzero(nonzero_t nz);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, nz.upper_bound, nz.lower_bound, nz.column_integer,
                     nz.coefficient, nz.column, nz.right_side, nz.row_number};
        s_tuser  <= nz.row_sense;
        s_tlast  <= nz.row_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_nonzero(nz);
        nz_accepted++;
        burst_left--;
    endtask

    task automatic send_rows(ref nonzero_t nz_q[$]);
        foreach (nz_q[i]) send_nonzero(nz_q[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_column_count(logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_column_count(value);
    endtask

    task automatic run_random_rows(int target);
        nonzero_t row_q[$];
        int       sent = 0;
        while (sent < target) begin
            gen_row(row_q);
            send_rows(row_q);
            sent += row_q.size();
        end
    endtask

    // result side: random ready pattern, one long hold-off to back up the pipeline
    initial begin
        int mode;
        int span;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held_once && nz_accepted >= 400) begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.literal       = m_tdata[16:0];
            got.row_echo      = m_tdata[36:17];
            got.clique_number = m_tdata[56:37];
            got.row_done      = m_tlast;
            got.is_clique     = m_tuser;
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        nonzero_t   directed_q[$];
        logic [16:0] cfg_list[$];
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // set packing L row, then G rows in both orientations (later sense/rhs ignored)
        append_nz(directed_q, make_nz(20'd0, SENSE_L, FIX_ONE, 16'd0, FIX_ONE, 1'b1, 0,
                                      FIX_ONE, 1'b0));
        append_nz(directed_q, make_nz(20'd0, SENSE_L, FIX_ONE, 16'hFFFF, FIX_ONE, 1'b1, 0,
                                      FIX_ONE, 1'b1));
        append_nz(directed_q, make_nz(20'd1, SENSE_G, FIX_ONE, 16'd5, FIX_ONE, 1'b1, 0,
                                      FIX_ONE, 1'b0));
        append_nz(directed_q, make_nz(20'd1, SENSE_OTHER, COEF_TOP, 16'hFFFF, FIX_ONE, 1'b1,
                                      FIX_ONE, FIX_ONE, 1'b1));
        append_nz(directed_q, make_nz(20'd2, SENSE_G, -FIX_ONE, 16'd7, -FIX_ONE, 1'b1, 0, 0,
                                      1'b0));
        append_nz(directed_q, make_nz(20'd2, SENSE_SPARE, 0, 16'd8, -FIX_ONE, 1'b1, 0, 0,
                                      1'b0));
        append_nz(directed_q, make_nz(20'd2, SENSE_L, 0, 16'd9, -FIX_ONE, 1'b1, 0, 0, 1'b1));
        // other sense codes never qualify
        append_nz(directed_q, make_nz(20'd3, SENSE_OTHER, FIX_ONE, 16'd1, FIX_ONE, 1'b1, 0, 0,
                                      1'b0));
        append_nz(directed_q, make_nz(20'd3, SENSE_OTHER, FIX_ONE, 16'd2, FIX_ONE, 1'b1, 0, 0,
                                      1'b1));
        append_nz(directed_q, make_nz(20'd4, SENSE_SPARE, FIX_ONE, 16'd1, FIX_ONE, 1'b1, 0, 0,
                                      1'b0));
        append_nz(directed_q, make_nz(20'd4, SENSE_SPARE, FIX_ONE, 16'd2, -FIX_ONE, 1'b1, 0,
                                      0, 1'b1));
        // single nonzero row
        append_nz(directed_q, make_nz(20'd5, SENSE_L, 0, 16'd3, FIX_ONE, 1'b1, 0, FIX_ONE,
                                      1'b1));
        // non-binary columns
        append_nz(directed_q, make_nz(20'd6, SENSE_L, FIX_ONE, 16'd4, -FIX_ONE, 1'b0, 0,
                                      FIX_ONE, 1'b0));
        append_nz(directed_q, make_nz(20'd6, SENSE_L, 0, 16'd6, FIX_ONE, 1'b1, -FIX_ONE,
                                      2 * FIX_ONE, 1'b1));
        // coefficients on both sides of the tolerance
        append_nz(directed_q, make_nz(20'd7, SENSE_L, 0, 16'd10, -EPS_LSB, 1'b1, 0, 0, 1'b0));
        append_nz(directed_q, make_nz(20'd7, SENSE_L, 0, 16'd11, -EPS_LSB + 1, 1'b1, 0, 0,
                                      1'b0));
        append_nz(directed_q, make_nz(20'd7, SENSE_L, 0, 16'd12, 0, 1'b1, 0, 0, 1'b0));
        append_nz(directed_q, make_nz(20'd7, SENSE_L, 0, 16'd13, EPS_LSB, 1'b1, 0, 0, 1'b1));
        // huge coefficients and rhs extremes
        append_nz(directed_q, make_nz(20'd8, SENSE_L, COEF_TOP, 16'hFFFF, -COEF_TOP - 1, 1'b1,
                                      FIX_ONE, 0, 1'b0));
        append_nz(directed_q, make_nz(20'd8, SENSE_L, 0, 16'hFFFE, COEF_TOP, 1'b1, 0, 0,
                                      1'b1));
        append_nz(directed_q, make_nz(20'd9, SENSE_G, -COEF_TOP - 1, 16'h8000, -COEF_TOP - 1,
                                      1'b1, 0, 0, 1'b0));
        append_nz(directed_q, make_nz(20'd9, SENSE_G, 0, 16'h7FFF, COEF_TOP, 1'b1, 0, 0,
                                      1'b1));
        // exactly on the verdict threshold, then just under it
        append_nz(directed_q, make_nz(20'hFFFFF, SENSE_L, 2 * FIX_ONE - EPS_LSB, 16'd20,
                                      FIX_ONE, 1'b1, 0, FIX_ONE, 1'b0));
        append_nz(directed_q, make_nz(20'hFFFFF, SENSE_L, 0, 16'd21, FIX_ONE, 1'b1, 0,
                                      FIX_ONE, 1'b1));
        append_nz(directed_q, make_nz(20'hFFFFE, SENSE_L, FIX_ONE / 2, 16'd22, FIX_ONE / 4,
                                      1'b1, 0, 0, 1'b0));
        append_nz(directed_q, make_nz(20'hFFFFE, SENSE_L, 0, 16'd23, FIX_ONE / 4, 1'b1, 0, 0,
                                      1'b1));
        send_rows(directed_q);
        run_random_rows(PHASE_ITEMS / 2);

        cfg_list = '{17'd1, 17'd131071, 17'd0, 17'($urandom_range(1, 65536)), 17'd65536};
        foreach (cfg_list[i]) begin
            wait_drained();
            write_column_count(cfg_list[i]);
            settings++;
            run_random_rows(PHASE_ITEMS);
        end

        wait_drained();
        repeat (LATENCY * 3) @(posedge aclk);
        $display("Sent %0d nonzeros in %0d rows (%0d clique rows) over %0d column_count values,",
                 nz_accepted, sb.rows_done, sb.cliques, settings);
        $display("with random bursts, receiver stalls and one long hold-off on the output.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/crc_pkg.sv
rtl/crc_row_track.sv
rtl/crc_verdict.sv
rtl/clique_row_classifier.sv
verif/testbench.sv
